// ----- src/gamma_pixel_reorder_writer_defines.svh -----
// assertion macros shared by the reorder writer
`ifndef GAMMA_PIXEL_REORDER_WRITER_DEFINES_SVH
`define GAMMA_PIXEL_REORDER_WRITER_DEFINES_SVH

// same-cycle implication, skipped while reset is high
`define GPRW_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gprw same-cycle check failed");

// next-cycle implication, skipped while reset is high
`define GPRW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gprw next-cycle check failed");

`endif

// ----- src/gprw_pkg.sv -----
package gprw_pkg;

   // frame store geometry
   localparam int MAX_PIXELS  = 65536;
   localparam int ADDR_W      = $clog2(MAX_PIXELS);
   localparam int EMIT_W      = ADDR_W + 1;
   localparam int INDEX_W     = 16;
   localparam int WORD_W      = 25;

   // drain burst
   localparam int DRAIN_BURST = 64;
   localparam int BURST_W     = $clog2(DRAIN_BURST + 1);

   // colour arithmetic
   localparam int COLOUR_BITS   = 8;
   localparam int FRACTION_BITS = 16;
   localparam int COMP_W        = 20;
   localparam int NUM_COMP      = 3;
   localparam int SEL_W         = 2;
   localparam int RAD_W         = 2 * COLOUR_BITS;
   localparam int WIDE_W        = COMP_W - 1 + RAD_W;
   localparam int SQ_W          = COMP_W - 1 + RAD_W - FRACTION_BITS;
   localparam int STEP_W        = $clog2(COLOUR_BITS);

   // coordinates and config
   localparam int COORD_W = 8;
   localparam int DIM_W   = 9;
   localparam int SIZE_W  = 2 * DIM_W;
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   // sized constants
   localparam logic [EMIT_W-1:0]  FRAME_LIMIT = EMIT_W'(MAX_PIXELS);
   localparam logic [SIZE_W-1:0]  PROD_LIMIT  = SIZE_W'(MAX_PIXELS);
   localparam logic [BURST_W-1:0] BURST_LIMIT = BURST_W'(DRAIN_BURST);
   localparam logic [STEP_W-1:0]  LAST_STEP   = STEP_W'(COLOUR_BITS - 1);
   localparam logic [SEL_W-1:0]   LAST_COMP   = SEL_W'(NUM_COMP - 1);
   localparam logic [DIM_W-1:0]   DIM_RESET   = DIM_W'(256);

   // register codes, taken from address bit 2
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_LOAD,
      ST_ROOT,
      ST_STORE,
      ST_READ,
      ST_CHECK
   } state_type;

endpackage

// ----- src/gamma_pixel_reorder_writer.sv -----
// an in-frame pixel transaction passes through setup, the shared square-root unit for
//   each of three components (a load step, then one result bit per cycle) and a store
// drain: a frame memory read, then a check, for each emitted pixel; it stops in a read
//   at the burst or frame end, or in a check that finds no ready bit
// reset: a pass over every address clears the frame memory ready bits, busy stays high
// results are strobed for one cycle each; the receiver cannot stall
`include "gamma_pixel_reorder_writer_defines.svh"

module gamma_pixel_reorder_writer (
   input  logic                                 clock,
   input  logic                                 reset,
   // item channel
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_kind,
   input  logic [gprw_pkg::COORD_W-1:0]         req_pixel_x,
   input  logic [gprw_pkg::COORD_W-1:0]         req_pixel_y,
   input  logic signed [gprw_pkg::COMP_W-1:0]   req_red_linear,
   input  logic signed [gprw_pkg::COMP_W-1:0]   req_green_linear,
   input  logic signed [gprw_pkg::COMP_W-1:0]   req_blue_linear,
   // result channel
   output logic                                 rsp_strobe,
   output logic [gprw_pkg::COLOUR_BITS-1:0]     rsp_red_byte,
   output logic [gprw_pkg::COLOUR_BITS-1:0]     rsp_green_byte,
   output logic [gprw_pkg::COLOUR_BITS-1:0]     rsp_blue_byte,
   output logic [gprw_pkg::INDEX_W-1:0]         rsp_emit_index,
   output logic                                 rsp_last_of_run,
   // register port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [gprw_pkg::PADDR_W-1:0]         paddr,
   input  logic [gprw_pkg::PDATA_W-1:0]         pwdata,
   output logic [gprw_pkg::PDATA_W-1:0]         prdata,
   output logic                                 pready
);

   gprw_pkg::state_type state_ff, state_in;

   // config registers
   logic [gprw_pkg::DIM_W-1:0] width_ff, height_ff;

   // captured transaction
   logic                                kind_ff;
   logic [gprw_pkg::COORD_W-1:0]        x_ff, y_ff;
   logic signed [gprw_pkg::COMP_W-1:0]  comp_ff [gprw_pkg::NUM_COMP];

   // address and frame size
   logic [gprw_pkg::SIZE_W-1:0] size_prod;
   logic [gprw_pkg::EMIT_W-1:0] size_in, size_ff;
   logic [gprw_pkg::EMIT_W-1:0] addr_sum;
   logic                        in_frame;
   logic [gprw_pkg::ADDR_W-1:0] addr_ff;

   // square-root unit
   logic [gprw_pkg::SEL_W-1:0]       comp_sel_ff;
   logic signed [gprw_pkg::COMP_W-1:0] raw;
   logic                             nonpos;
   logic [gprw_pkg::WIDE_W-1:0]      scale_wide;
   logic [gprw_pkg::SQ_W-1:0]        scaled;
   logic [gprw_pkg::RAD_W-1:0]       rad_ff;
   logic [gprw_pkg::COLOUR_BITS+1:0] rem_ff, rem_try, trial;
   logic [gprw_pkg::COLOUR_BITS-1:0] root_ff, root_next;
   logic                             root_ge;
   logic                             sat_ff;
   logic [gprw_pkg::STEP_W-1:0]      step_ff;
   logic                             last_step;
   logic [gprw_pkg::COLOUR_BITS-1:0] byte_ff [gprw_pkg::NUM_COMP];

   // frame memory, valid bit on top of the colour triple
   logic [gprw_pkg::WORD_W-1:0] pix_mem [gprw_pkg::MAX_PIXELS];
   logic [gprw_pkg::WORD_W-1:0] rd_word_ff;
   logic [gprw_pkg::WORD_W-1:0] mem_wdata;
   logic [gprw_pkg::ADDR_W-1:0] mem_waddr;
   logic [gprw_pkg::ADDR_W-1:0] clr_addr_ff;

   // drain
   logic [gprw_pkg::EMIT_W-1:0]      next_emit_ff;
   logic [gprw_pkg::BURST_W-1:0]     emit_cnt_ff;
   logic                             pend_ff;
   logic [3*gprw_pkg::COLOUR_BITS-1:0] pend_data_ff;
   logic [gprw_pkg::INDEX_W-1:0]     pend_idx_ff;
   logic                             stop_drain;

   // control
   logic accept, cfg_write;
   logic mem_we, mem_clear, mem_re, take_pixel, finish, emit, emit_last;

   // result registers
   logic                             rsp_strobe_ff, rsp_last_ff;
   logic [3*gprw_pkg::COLOUR_BITS-1:0] rsp_data_ff;
   logic [gprw_pkg::INDEX_W-1:0]     rsp_idx_ff;

   // frame size and linear address
   assign size_prod = gprw_pkg::SIZE_W'(width_ff) * gprw_pkg::SIZE_W'(height_ff);
   assign size_in   = (size_prod > gprw_pkg::PROD_LIMIT) ? gprw_pkg::FRAME_LIMIT
                                                         : size_prod[gprw_pkg::EMIT_W-1:0];
   assign addr_sum  = gprw_pkg::EMIT_W'(y_ff) * gprw_pkg::EMIT_W'(width_ff)
                      + gprw_pkg::EMIT_W'(x_ff);
   assign in_frame  = !kind_ff && (gprw_pkg::DIM_W'(x_ff) < width_ff)
                      && (gprw_pkg::DIM_W'(y_ff) < height_ff) && (addr_sum < size_in);

   // component load: scale and classify
   assign raw        = comp_ff[comp_sel_ff];
   assign nonpos     = raw[gprw_pkg::COMP_W-1] || (raw == '0);
   assign scale_wide = {raw[gprw_pkg::COMP_W-2:0], {gprw_pkg::RAD_W{1'b0}}}
                       >> gprw_pkg::FRACTION_BITS;
   assign scaled     = scale_wide[gprw_pkg::SQ_W-1:0];

   // one restoring square-root step
   assign rem_try   = {rem_ff[gprw_pkg::COLOUR_BITS-1:0], rad_ff[gprw_pkg::RAD_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign root_ge   = (rem_try >= trial);
   assign root_next = {root_ff[gprw_pkg::COLOUR_BITS-2:0], root_ge};
   assign last_step = (step_ff == gprw_pkg::LAST_STEP);

   // drain stop test
   assign stop_drain = (emit_cnt_ff == gprw_pkg::BURST_LIMIT) || (next_emit_ff >= size_ff);

   assign accept    = start && (state_ff == gprw_pkg::ST_IDLE);
   assign cfg_write = psel && penable && pwrite && pready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gprw_pkg::ST_CLEAR: begin
            if (clr_addr_ff == '1) state_in = gprw_pkg::ST_IDLE;
         end
         gprw_pkg::ST_IDLE: begin
            if (start) state_in = gprw_pkg::ST_SETUP;
         end
         gprw_pkg::ST_SETUP: begin
            state_in = in_frame ? gprw_pkg::ST_LOAD : gprw_pkg::ST_READ;
         end
         gprw_pkg::ST_LOAD: begin
            state_in = gprw_pkg::ST_ROOT;
         end
         gprw_pkg::ST_ROOT: begin
            if (last_step) begin
               state_in = (comp_sel_ff == gprw_pkg::LAST_COMP) ? gprw_pkg::ST_STORE
                                                               : gprw_pkg::ST_LOAD;
            end
         end
         gprw_pkg::ST_STORE: begin
            state_in = gprw_pkg::ST_READ;
         end
         gprw_pkg::ST_READ: begin
            state_in = stop_drain ? gprw_pkg::ST_IDLE : gprw_pkg::ST_CHECK;
         end
         gprw_pkg::ST_CHECK: begin
            state_in = rd_word_ff[gprw_pkg::WORD_W-1] ? gprw_pkg::ST_READ : gprw_pkg::ST_IDLE;
         end
         default: begin
            state_in = gprw_pkg::ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      busy       = 1'b1;
      mem_we     = 1'b0;
      mem_clear  = 1'b0;
      mem_re     = 1'b0;
      take_pixel = 1'b0;
      finish     = 1'b0;
      case (state_ff)
         gprw_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_clear = 1'b1;
         end
         gprw_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         gprw_pkg::ST_STORE: begin
            mem_we = 1'b1;
         end
         gprw_pkg::ST_READ: begin
            mem_re = !stop_drain;
            finish = stop_drain;
         end
         gprw_pkg::ST_CHECK: begin
            take_pixel = rd_word_ff[gprw_pkg::WORD_W-1];
            finish     = !rd_word_ff[gprw_pkg::WORD_W-1];
         end
         default: begin
            busy = 1'b1;
         end
      endcase
      emit      = pend_ff && (take_pixel || finish);
      emit_last = finish;
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gprw_pkg::ST_CLEAR;
         clr_addr_ff   <= '0;
         next_emit_ff  <= '0;
         emit_cnt_ff   <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         width_ff      <= gprw_pkg::DIM_RESET;
         height_ff     <= gprw_pkg::DIM_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= emit;
         if (mem_clear) clr_addr_ff <= clr_addr_ff + 1'b1;
         if (accept) emit_cnt_ff <= '0;
         if (take_pixel) begin
            next_emit_ff <= next_emit_ff + 1'b1;
            emit_cnt_ff  <= emit_cnt_ff + 1'b1;
            pend_ff      <= 1'b1;
         end
         if (finish) pend_ff <= 1'b0;
         // register writes
         if (cfg_write) begin
            if (paddr[2] == gprw_pkg::REG_IMAGE_WIDTH) begin
               width_ff <= pwdata[gprw_pkg::DIM_W-1:0];
            end else begin
               height_ff <= pwdata[gprw_pkg::DIM_W-1:0];
            end
         end
      end
   end

   // transaction capture and square-root datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff    <= req_kind;
         x_ff       <= req_pixel_x;
         y_ff       <= req_pixel_y;
         comp_ff[0] <= req_red_linear;
         comp_ff[1] <= req_green_linear;
         comp_ff[2] <= req_blue_linear;
      end
      if (state_ff == gprw_pkg::ST_SETUP) begin
         size_ff     <= size_in;
         addr_ff     <= addr_sum[gprw_pkg::ADDR_W-1:0];
         comp_sel_ff <= '0;
      end
      if (state_ff == gprw_pkg::ST_LOAD) begin
         rad_ff  <= nonpos ? '0 : scaled[gprw_pkg::RAD_W-1:0];
         sat_ff  <= !nonpos && (scaled[gprw_pkg::SQ_W-1:gprw_pkg::RAD_W] != '0);
         rem_ff  <= '0;
         root_ff <= '0;
         step_ff <= '0;
      end
      if (state_ff == gprw_pkg::ST_ROOT) begin
         rem_ff  <= root_ge ? (rem_try - trial) : rem_try;
         root_ff <= root_next;
         rad_ff  <= rad_ff << 2;
         step_ff <= step_ff + 1'b1;
         if (last_step) begin
            byte_ff[comp_sel_ff] <= sat_ff ? '1 : root_next;
            comp_sel_ff          <= comp_sel_ff + 1'b1;
         end
      end
   end

   // frame memory write mux
   assign mem_waddr = mem_clear ? clr_addr_ff : addr_ff;
   assign mem_wdata = mem_clear ? '0 : {1'b1, byte_ff[0], byte_ff[1], byte_ff[2]};

   // frame memory
   always_ff @(posedge clock) begin
      if (mem_we) pix_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_word_ff <= pix_mem[next_emit_ff[gprw_pkg::ADDR_W-1:0]];
   end

   // pending pixel and result registers
   always_ff @(posedge clock) begin
      if (take_pixel) begin
         pend_data_ff <= rd_word_ff[3*gprw_pkg::COLOUR_BITS-1:0];
         pend_idx_ff  <= next_emit_ff[gprw_pkg::INDEX_W-1:0];
      end
      if (emit) begin
         rsp_data_ff <= pend_data_ff;
         rsp_idx_ff  <= pend_idx_ff;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_red_byte    = rsp_data_ff[3*gprw_pkg::COLOUR_BITS-1 -: gprw_pkg::COLOUR_BITS];
   assign rsp_green_byte  = rsp_data_ff[2*gprw_pkg::COLOUR_BITS-1 -: gprw_pkg::COLOUR_BITS];
   assign rsp_blue_byte   = rsp_data_ff[gprw_pkg::COLOUR_BITS-1:0];
   assign rsp_emit_index  = rsp_idx_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // register read back
   assign pready = 1'b1;
   assign prdata = (paddr[2] == gprw_pkg::REG_IMAGE_WIDTH) ? gprw_pkg::PDATA_W'(width_ff)
                                                           : gprw_pkg::PDATA_W'(height_ff);

   // checks
   `GPRW_ASSERT_SAME(a_no_result_in_clear, clock, reset, state_ff == gprw_pkg::ST_CLEAR, !rsp_strobe)
   `GPRW_ASSERT_SAME(a_burst_bound, clock, reset, 1'b1, emit_cnt_ff <= gprw_pkg::BURST_LIMIT)
   `GPRW_ASSERT_NEXT(a_pointer_moves_on_check, clock, reset, state_ff != gprw_pkg::ST_CHECK, $stable(next_emit_ff))
   `GPRW_ASSERT_NEXT(a_last_ends_run, clock, reset, rsp_strobe && rsp_last_of_run, !rsp_strobe)

endmodule

// ----- sim/pixel_item_pkg.sv -----
`timescale 1ns / 1ps
package pixel_item_pkg;

   // transaction kinds on the item channel
   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_DRAIN = 1'b1
   } item_kind_type;

endpackage

// ----- sim/pixel_emit_checker.sv -----
`timescale 1ns / 1ps
module pixel_emit_checker import gprw_pkg::*, pixel_item_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic                      req_kind,
   input  logic [COORD_W-1:0]        req_pixel_x,
   input  logic [COORD_W-1:0]        req_pixel_y,
   input  logic signed [COMP_W-1:0]  req_red_linear,
   input  logic signed [COMP_W-1:0]  req_green_linear,
   input  logic signed [COMP_W-1:0]  req_blue_linear,
   input  logic                      rsp_strobe,
   input  logic [COLOUR_BITS-1:0]    rsp_red_byte,
   input  logic [COLOUR_BITS-1:0]    rsp_green_byte,
   input  logic [COLOUR_BITS-1:0]    rsp_blue_byte,
   input  logic [INDEX_W-1:0]        rsp_emit_index,
   input  logic                      rsp_last_of_run,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [PADDR_W-1:0]        paddr,
   input  logic [PDATA_W-1:0]        pwdata,
   input  logic                      pready,
   output int                        mismatches,
   output int                        pixels_pending
);

   // one emitted pixel as it should appear on the result ports
   typedef struct packed {
      logic [COLOUR_BITS-1:0] red;
      logic [COLOUR_BITS-1:0] green;
      logic [COLOUR_BITS-1:0] blue;
      logic [INDEX_W-1:0]     index;
      logic                   last_of_run;
   } raster_pixel_t;

   localparam longint unsigned TOP_BYTE = (64'd1 << COLOUR_BITS) - 1;

   logic [DIM_W-1:0]         frame_width;
   logic [DIM_W-1:0]         frame_height;
   logic [EMIT_W-1:0]        emit_pointer;
   bit                       ready_mark [MAX_PIXELS];
   logic [3*COLOUR_BITS-1:0] colour_store [MAX_PIXELS];
   raster_pixel_t            expected_pixels [$];
   raster_pixel_t            oldest;

   // gamma-2 correction: floor square root of the scaled linear value
   function automatic logic [COLOUR_BITS-1:0] gamma_byte(input logic signed [COMP_W-1:0] linear);
      longint unsigned scaled;
      longint unsigned root;
      longint unsigned trial;
      if (linear <= 0)
         return '0;
      scaled = linear;
      scaled = (scaled << (2 * COLOUR_BITS)) >> FRACTION_BITS;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= scaled)
            root = trial;
      end
      if (root > TOP_BYTE)
         root = TOP_BYTE;
      return root[COLOUR_BITS-1:0];
   endfunction

   // width times height, saturated to the store depth
   function automatic int unsigned frame_pixels();
      int unsigned area;
      area = int'(frame_width) * int'(frame_height);
      return (area > MAX_PIXELS) ? MAX_PIXELS : area;
   endfunction

   // store an in-frame pixel item, then queue the ready run from the emit pointer
   task automatic take_item(input logic kind, input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic signed [COMP_W-1:0] r, input logic signed [COMP_W-1:0] g,
                            input logic signed [COMP_W-1:0] b);
      int unsigned frame_len;
      int unsigned addr;
      int burst;
      raster_pixel_t px;
      frame_len = frame_pixels();
      if (kind == KIND_PIXEL && x < frame_width && y < frame_height) begin
         addr = int'(y) * int'(frame_width) + int'(x);
         if (addr < frame_len) begin
            colour_store[addr] = {gamma_byte(r), gamma_byte(g), gamma_byte(b)};
            ready_mark[addr] = 1'b1;
         end
      end
      burst = 0;
      while (burst < DRAIN_BURST && emit_pointer < frame_len && ready_mark[emit_pointer]) begin
         {px.red, px.green, px.blue} = colour_store[emit_pointer];
         px.index = emit_pointer[INDEX_W-1:0];
         emit_pointer = emit_pointer + 1'b1;
         burst++;
         px.last_of_run = burst == DRAIN_BURST || emit_pointer >= frame_len ||
                          !ready_mark[emit_pointer];
         expected_pixels.push_back(px);
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $display("time %0t: %s of pixel %0d expected %0d, got %0d",
                  $time, field, oldest.index, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (ready_mark[i]) ready_mark[i] = 1'b0;
         emit_pointer = '0;
         frame_width = DIM_RESET;
         frame_height = DIM_RESET;
         expected_pixels.delete();
         mismatches = 0;
      end else begin
         // emitted pixel against the oldest prediction
         if (rsp_strobe === 1'b1) begin
            if (expected_pixels.size() == 0) begin
               $display("time %0t: expected no pixel, got pixel %0d", $time, rsp_emit_index);
               mismatches++;
            end else begin
               oldest = expected_pixels.pop_front();
               check_field("red_byte", oldest.red, rsp_red_byte);
               check_field("green_byte", oldest.green, rsp_green_byte);
               check_field("blue_byte", oldest.blue, rsp_blue_byte);
               check_field("emit_index", oldest.index, rsp_emit_index);
               check_field("last_of_run", oldest.last_of_run, rsp_last_of_run);
            end
         end
         // register write transaction
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_IMAGE_WIDTH) frame_width = pwdata[DIM_W-1:0];
            else frame_height = pwdata[DIM_W-1:0];
         end
         // item transaction
         if (start === 1'b1 && busy === 1'b0)
            take_item(req_kind, req_pixel_x, req_pixel_y,
                      req_red_linear, req_green_linear, req_blue_linear);
      end
      pixels_pending = expected_pixels.size();
   end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

   localparam int RESET_CYCLES = 5;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_SLACK  = 40 + 2 * gprw_pkg::DRAIN_BURST;
   localparam logic signed [gprw_pkg::COMP_W-1:0] LINEAR_MAX =
      {1'b0, {(gprw_pkg::COMP_W-1){1'b1}}};
   localparam logic signed [gprw_pkg::COMP_W-1:0] LINEAR_MIN =
      {1'b1, {(gprw_pkg::COMP_W-1){1'b0}}};

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic                                req_kind = pixel_item_pkg::KIND_PIXEL;
   logic [gprw_pkg::COORD_W-1:0]        req_pixel_x = '0;
   logic [gprw_pkg::COORD_W-1:0]        req_pixel_y = '0;
   logic signed [gprw_pkg::COMP_W-1:0]  req_red_linear = '0;
   logic signed [gprw_pkg::COMP_W-1:0]  req_green_linear = '0;
   logic signed [gprw_pkg::COMP_W-1:0]  req_blue_linear = '0;
   logic                                rsp_strobe;
   logic [gprw_pkg::COLOUR_BITS-1:0]    rsp_red_byte;
   logic [gprw_pkg::COLOUR_BITS-1:0]    rsp_green_byte;
   logic [gprw_pkg::COLOUR_BITS-1:0]    rsp_blue_byte;
   logic [gprw_pkg::INDEX_W-1:0]        rsp_emit_index;
   logic                                rsp_last_of_run;
   logic                                psel = 1'b0;
   logic                                penable = 1'b0;
   logic                                pwrite = 1'b0;
   logic [gprw_pkg::PADDR_W-1:0]        paddr = '0;
   logic [gprw_pkg::PDATA_W-1:0]        pwdata = '0;
   logic [gprw_pkg::PDATA_W-1:0]        prdata;
   logic                                pready;

   int          mismatches;
   int          pixels_pending;
   int          cycle_count = 0;
   int          items_sent = 0;
   bit          idle_on = 1'b1;
   int unsigned cursor = 0;
   int unsigned cfg_width = 256;
   int unsigned cfg_height = 256;
   bit          written_mark [gprw_pkg::MAX_PIXELS];

   gamma_pixel_reorder_writer DUT (.*);

   pixel_emit_checker emit_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic int unsigned frame_limit();
      int unsigned area;
      area = cfg_width * cfg_height;
      return (area > gprw_pkg::MAX_PIXELS) ? gprw_pkg::MAX_PIXELS : area;
   endfunction

   // raster address reachable with 8-bit coordinates in the current frame
   function automatic bit mappable(input int unsigned addr);
      return cfg_width != 0 && addr < frame_limit() &&
             addr % cfg_width < (1 << gprw_pkg::COORD_W) &&
             addr / cfg_width < (1 << gprw_pkg::COORD_W);
   endfunction

   // sized linear component from a plain integer
   function automatic logic signed [gprw_pkg::COMP_W-1:0] as_linear(input int value);
      return gprw_pkg::COMP_W'(value);
   endfunction

   // mix of saturating, mid-range, small and negative linear values
   function automatic logic signed [gprw_pkg::COMP_W-1:0] random_linear();
      case ($urandom_range(3))
         0: return gprw_pkg::COMP_W'($urandom);
         1: return gprw_pkg::COMP_W'($urandom_range(65100));
         2: return gprw_pkg::COMP_W'($urandom_range(300));
         default: return gprw_pkg::COMP_W'($urandom) | LINEAR_MIN;
      endcase
   endfunction

   // one item transaction, with a random hold-off once the block is free
   task automatic drive_item(input pixel_item_pkg::item_kind_type kind,
                             input logic [gprw_pkg::COORD_W-1:0] x,
                             input logic [gprw_pkg::COORD_W-1:0] y,
                             input logic signed [gprw_pkg::COMP_W-1:0] r,
                             input logic signed [gprw_pkg::COMP_W-1:0] g,
                             input logic signed [gprw_pkg::COMP_W-1:0] b);
      int gap;
      gap = 0;
      if (idle_on)
         while ($urandom_range(99) < 30) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         // first idle cycle is the one in which busy is seen low
         do @(posedge clock); while (busy !== 1'b0);
         repeat (gap - 1) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_pixel_x <= x;
      req_pixel_y <= y;
      req_red_linear <= r;
      req_green_linear <= g;
      req_blue_linear <= b;
      do @(posedge clock); while (busy !== 1'b0);
      items_sent++;
   endtask

   task automatic send_pixel(input int unsigned x, input int unsigned y,
                             input logic signed [gprw_pkg::COMP_W-1:0] r,
                             input logic signed [gprw_pkg::COMP_W-1:0] g,
                             input logic signed [gprw_pkg::COMP_W-1:0] b);
      if (x < cfg_width && y < cfg_height && y * cfg_width + x < frame_limit())
         written_mark[y * cfg_width + x] = 1'b1;
      drive_item(pixel_item_pkg::KIND_PIXEL, x[gprw_pkg::COORD_W-1:0],
                 y[gprw_pkg::COORD_W-1:0], r, g, b);
   endtask

   // drain with junk in the ignored fields
   task automatic send_drain();
      drive_item(pixel_item_pkg::KIND_DRAIN, gprw_pkg::COORD_W'($urandom),
                 gprw_pkg::COORD_W'($urandom), gprw_pkg::COMP_W'($urandom),
                 gprw_pkg::COMP_W'($urandom), gprw_pkg::COMP_W'($urandom));
   endtask

   // drain or a pixel anywhere, often out of frame
   task automatic noise_item();
      if ($urandom_range(99) < 35) send_drain();
      else send_pixel($urandom_range(255), $urandom_range(255),
                      random_linear(), random_linear(), random_linear());
   endtask

   task automatic advance_cursor();
      while (cursor < gprw_pkg::MAX_PIXELS && written_mark[cursor]) cursor++;
   endtask

   // fill the next run of raster addresses out of order, with noise mixed in
   task automatic run_window(input int unsigned max_len, input bit descending);
      int unsigned addr_list [$];
      int unsigned len;
      int unsigned a;
      int unsigned swap_addr;
      int j;
      len = descending ? max_len : $urandom_range(max_len, 1);
      a = cursor;
      while (addr_list.size() < len && mappable(a)) begin
         if (descending) addr_list.push_front(a);
         else addr_list.push_back(a);
         a++;
      end
      if (addr_list.size() == 0) begin
         noise_item();
         return;
      end
      if (!descending) begin
         for (int i = addr_list.size() - 1; i > 0; i--) begin
            j = $urandom_range(i);
            swap_addr = addr_list[i];
            addr_list[i] = addr_list[j];
            addr_list[j] = swap_addr;
         end
      end
      foreach (addr_list[i]) begin
         if ($urandom_range(99) < 15) noise_item();
         send_pixel(addr_list[i] % cfg_width, addr_list[i] / cfg_width,
                    random_linear(), random_linear(), random_linear());
      end
      advance_cursor();
   endtask

   // wait for every predicted pixel, then let a pending drain finish
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (pixels_pending != 0);
      repeat (DRAIN_SLACK) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic write_reg(input logic register_sel, input int unsigned value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {register_sel, 2'b00};
      pwdata <= gprw_pkg::PDATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_frame(input int unsigned w, input int unsigned h);
      settle();
      write_reg(gprw_pkg::REG_IMAGE_WIDTH, w);
      write_reg(gprw_pkg::REG_IMAGE_HEIGHT, h);
      cfg_width = w;
      cfg_height = h;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      // ready bits are cleared after reset
      do @(posedge clock); while (busy !== 1'b0);

      // reset frame: drain on empty store, component extremes, out-of-order start
      send_drain();
      send_pixel(255, 255, LINEAR_MAX, LINEAR_MIN, '0);
      send_pixel(1, 0, as_linear(1), as_linear(-1), as_linear(65025));
      send_pixel(0, 0, as_linear(65024), as_linear(65026), as_linear(3));
      send_pixel(2, 0, as_linear(4), as_linear(8), as_linear(100));
      send_drain();
      advance_cursor();

      // 4x4 frame: off-frame pixels, fill to completion, then nothing more
      set_frame(4, 4);
      send_pixel(4, 0, LINEAR_MAX, LINEAR_MAX, LINEAR_MAX);
      send_pixel(0, 4, LINEAR_MAX, LINEAR_MAX, LINEAR_MAX);
      send_pixel(255, 255, LINEAR_MAX, LINEAR_MAX, LINEAR_MAX);
      while (cursor < 16) run_window(4, 1'b0);
      send_pixel(1, 1, as_linear(400), as_linear(900), as_linear(1600));
      send_drain();

      // empty frame
      set_frame(0, 0);
      send_pixel(0, 0, as_linear(100), as_linear(100), as_linear(100));
      send_drain();

      // single column
      set_frame(1, 256);
      while (items_sent < 110) run_window(8, 1'b0);

      // frame shrunk below the emit pointer
      set_frame(16, 1);
      send_pixel(3, 0, as_linear(50), as_linear(60), as_linear(70));
      send_pixel(15, 0, as_linear(50), as_linear(60), as_linear(70));
      send_drain();

      // oversized frame, saturated to the store depth
      set_frame(511, 511);
      while (items_sent < 160) run_window(8, 1'b0);

      // full frame, back to back, then a run longer than one burst
      set_frame(256, 256);
      idle_on = 1'b0;
      while (items_sent < 220) run_window(8, 1'b0);
      run_window(gprw_pkg::DRAIN_BURST + 6, 1'b1);
      idle_on = 1'b1;
      while (items_sent < 370) run_window(8, 1'b0);

      settle();
      if (mismatches == 0 && pixels_pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
